/* src/fsr_pkg.sv */
// shared types and constants for the stuffed frame receiver
// no dependencies
package fsr_pkg;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAG_BYTE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_BYTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_MASK = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SHORT    = 3'd1;
   localparam logic [2:0] ST_BADLEN   = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_CRC      = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   typedef enum logic [1:0] {
      OP_STORE,
      OP_CLOSE,
      OP_OVERFLOW
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_type;

endpackage

/* src/fsr_if.sv */
// request and response channel interfaces
// no dependencies
interface fsr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface fsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  frame_status;
   logic [7:0]  message_type;
   logic [6:0]  payload_length;
   logic [7:0]  data_byte;
   logic        data_present;
   logic [5:0]  byte_position;
   logic        last_of_run;
   logic [31:0] good_frames;
   logic [31:0] format_errors;
   logic [31:0] crc_errors;
   modport source (output valid, input ready, output frame_status, output message_type,
                   output payload_length, output data_byte, output data_present,
                   output byte_position, output last_of_run, output good_frames,
                   output format_errors, output crc_errors);
   modport sink (input valid, output ready, input frame_status, input message_type,
                 input payload_length, input data_byte, input data_present,
                 input byte_position, input last_of_run, input good_frames,
                 input format_errors, input crc_errors);
endinterface

/* src/stuffed_frame_receiver_crc16.sv */
// stuffed frame receiver top level: front, command queue, back
// results: once the closing flag is accepted, an error or empty-payload result passes through
// the queue and the result register, and a payload result also through S_READ and S_EMIT
// throughput: one line byte per cycle into a 4-entry queue when not full; stored bytes drain
// at one per cycle while the back end is idle; payload results use a registered store read
// reset: synchronous, idle, counters zero, config to flag 0x7E, escape 0x7D, mask 0x20
module stuffed_frame_receiver_crc16 #(
   parameter int MAX_PAYLOAD = 64,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fsr_pkg::CSR_DATA_W-1:0]  csr_data,
   fsr_req_if.sink                         req_chan,
   fsr_rsp_if.source                       rsp_chan
);
   import fsr_pkg::*;

   logic    push, full, pop, empty;
   cmd_type push_data, head;

   fsr_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req        (req_chan),
      .push_valid (push),
      .push_data  (push_data),
      .fifo_full  (full)
   );

   fsr_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   fsr_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

/* src/fsr_front.sv */
// front end: config registers, flag and escape handling, command generation
// depends on fsr_pkg and fsr_if
module fsr_front #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [fsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fsr_pkg::CSR_DATA_W-1:0]  csr_data,
   fsr_req_if.sink                         req,
   output logic                            push_valid,
   output fsr_pkg::cmd_type                push_data,
   input  logic                            fifo_full
);
   import fsr_pkg::*;

   localparam int STORE_DEPTH = MAX_PAYLOAD + 5;
   localparam int FILL_W = $clog2(STORE_DEPTH + 1);

   logic [7:0]        flag_ff, esc_byte_ff, mask_ff;
   logic              recv_ff, recv_in;
   logic              esc_ff, esc_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              accept;
   logic              do_store;
   logic [7:0]        store_byte;

   assign req.ready = !fifo_full;
   assign accept = req.valid && !fifo_full;

   always_comb begin
      recv_in = recv_ff;
      esc_in = esc_ff;
      fill_in = fill_ff;
      push_valid = 1'b0;
      push_data.op = OP_STORE;
      push_data.data = req.rx_byte;
      do_store = 1'b0;
      store_byte = req.rx_byte;
      if (accept) begin
         if (!recv_ff) begin
            if (req.rx_byte == flag_ff) begin
               recv_in = 1'b1;
               esc_in = 1'b0;
               fill_in = '0;
            end
         end else if (esc_ff) begin
            esc_in = 1'b0;
            store_byte = req.rx_byte ^ mask_ff;
            do_store = 1'b1;
         end else if (req.rx_byte == esc_byte_ff) begin
            esc_in = 1'b1;
         end else if (req.rx_byte == flag_ff) begin
            recv_in = 1'b0;
            push_valid = 1'b1;
            push_data.op = OP_CLOSE;
         end else begin
            do_store = 1'b1;
         end
         if (do_store) begin
            push_valid = 1'b1;
            push_data.data = store_byte;
            if (fill_ff < FILL_W'(STORE_DEPTH)) begin
               push_data.op = OP_STORE;
               fill_in = fill_ff + 1'b1;
            end else begin
               push_data.op = OP_OVERFLOW;
               recv_in = 1'b0;
               esc_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 8'h7E;
         esc_byte_ff <= 8'h7D;
         mask_ff <= 8'h20;
         recv_ff <= 1'b0;
         esc_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         recv_ff <= recv_in;
         esc_ff <= esc_in;
         fill_ff <= fill_in;
         if (csr_write) begin
            case (csr_index)
               CSR_FLAG_BYTE:   flag_ff <= csr_data;
               CSR_ESCAPE_BYTE: esc_byte_ff <= csr_data;
               CSR_ESCAPE_MASK: mask_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

/* src/fsr_fifo.sv */
// short command queue between front and back
// depends on fsr_pkg
module fsr_fifo #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fsr_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output fsr_pkg::cmd_type head,
   output logic             empty
);
   import fsr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W:0]   wr_ptr_ff, rd_ptr_ff;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full = (wr_ptr_ff[PTR_W-1:0] == rd_ptr_ff[PTR_W-1:0]) &&
                 (wr_ptr_ff[PTR_W] != rd_ptr_ff[PTR_W]);
   assign head = slot_ff[rd_ptr_ff[PTR_W-1:0]];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff[PTR_W-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

/* src/fsr_back.sv */
// back end: frame store, running crc, close checks, counters and result register
// depends on fsr_pkg and fsr_if
module fsr_back #(
   parameter int MAX_PAYLOAD = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  fsr_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   fsr_rsp_if.source        rsp
);
   import fsr_pkg::*;

   localparam int STORE_DEPTH = MAX_PAYLOAD + 5;
   localparam int FILL_W = $clog2(STORE_DEPTH + 1);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      r = c ^ {d, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic [7:0]        mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        h1_ff, h1_in, h2_ff, h2_in;
   logic [7:0]        len_hi_ff, len_hi_in, len_lo_ff, len_lo_in;
   logic [7:0]        type_ff, type_in;
   logic [6:0]        plen_ff, plen_in;
   logic [5:0]        pos_ff, pos_in;
   logic [31:0]       good_ff, good_in, fmt_ff, fmt_in, crcerr_ff, crcerr_in;

   logic              rv_ff, rv_in;
   logic [2:0]        o_status_ff, o_status_in;
   logic [7:0]        o_type_ff, o_type_in;
   logic [6:0]        o_plen_ff, o_plen_in;
   logic [7:0]        o_data_ff, o_data_in;
   logic              o_present_ff, o_present_in;
   logic [5:0]        o_pos_ff, o_pos_in;
   logic              o_last_ff, o_last_in;

   logic              out_free;
   logic [15:0]       len;
   logic [16:0]       len_plus4;
   logic              is_short, is_badlen, is_mismatch, is_crcbad;
   logic              load;
   logic              run_last;

   assign out_free = !rv_ff || rsp.ready;
   assign len = {len_hi_ff, len_lo_ff};
   assign len_plus4 = {1'b0, len} + 17'd4;
   assign is_short = fill_ff < FILL_W'(5);
   assign is_badlen = (len == 16'd0) || (len > 16'(MAX_PAYLOAD + 1));
   assign is_mismatch = 17'(fill_ff) != len_plus4;
   assign is_crcbad = {h2_ff, h1_ff} != crc_ff;
   assign rd_addr = ADDR_W'(pos_ff) + ADDR_W'(3);
   assign run_last = (7'(pos_ff) + 7'd1) == plen_ff;
   assign pop = (state_ff == S_IDLE) && !empty && ((head.op == OP_STORE) || out_free);

   always_ff @(posedge clock) begin
      if (pop && (head.op == OP_STORE)) begin
         mem[fill_ff[ADDR_W-1:0]] <= head.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      crc_in = crc_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      len_hi_in = len_hi_ff;
      len_lo_in = len_lo_ff;
      type_in = type_ff;
      plen_in = plen_ff;
      pos_in = pos_ff;
      good_in = good_ff;
      fmt_in = fmt_ff;
      crcerr_in = crcerr_ff;
      load = 1'b0;
      o_status_in = ST_OK;
      o_type_in = 8'd0;
      o_plen_in = 7'd0;
      o_data_in = 8'd0;
      o_present_in = 1'b0;
      o_pos_in = 6'd0;
      o_last_in = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               case (head.op)
                  OP_STORE: begin
                     fill_in = fill_ff + 1'b1;
                     h1_in = head.data;
                     h2_in = h1_ff;
                     if (fill_ff >= FILL_W'(2)) begin
                        crc_in = crc16_byte(crc_ff, h2_ff);
                     end
                     if (fill_ff == FILL_W'(0)) begin
                        len_hi_in = head.data;
                     end
                     if (fill_ff == FILL_W'(1)) begin
                        len_lo_in = head.data;
                     end
                     if (fill_ff == FILL_W'(2)) begin
                        type_in = head.data;
                     end
                  end
                  OP_CLOSE: begin
                     fill_in = '0;
                     crc_in = CRC_INIT;
                     if (is_short) begin
                        fmt_in = fmt_ff + 32'd1;
                        o_status_in = ST_SHORT;
                        load = 1'b1;
                     end else if (is_badlen) begin
                        fmt_in = fmt_ff + 32'd1;
                        o_status_in = ST_BADLEN;
                        load = 1'b1;
                     end else if (is_mismatch) begin
                        fmt_in = fmt_ff + 32'd1;
                        o_status_in = ST_MISMATCH;
                        load = 1'b1;
                     end else if (is_crcbad) begin
                        crcerr_in = crcerr_ff + 32'd1;
                        o_status_in = ST_CRC;
                        load = 1'b1;
                     end else begin
                        good_in = good_ff + 32'd1;
                        plen_in = len[6:0] - 7'd1;
                        if (len[6:0] == 7'd1) begin
                           o_type_in = type_ff;
                           load = 1'b1;
                        end else begin
                           pos_in = 6'd0;
                           state_in = S_READ;
                        end
                     end
                  end
                  OP_OVERFLOW: begin
                     fill_in = '0;
                     crc_in = CRC_INIT;
                     fmt_in = fmt_ff + 32'd1;
                     o_status_in = ST_OVERFLOW;
                     load = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               o_type_in = type_ff;
               o_plen_in = plen_ff;
               o_data_in = rd_data_ff;
               o_present_in = 1'b1;
               o_pos_in = pos_ff;
               o_last_in = run_last;
               if (run_last) begin
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff + 6'd1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rv_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      len_hi_ff <= len_hi_in;
      len_lo_ff <= len_lo_in;
      type_ff <= type_in;
      plen_ff <= plen_in;
      pos_ff <= pos_in;
      if (load) begin
         o_status_ff <= o_status_in;
         o_type_ff <= o_type_in;
         o_plen_ff <= o_plen_in;
         o_data_ff <= o_data_in;
         o_present_ff <= o_present_in;
         o_pos_ff <= o_pos_in;
         o_last_ff <= o_last_in;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         crc_ff <= CRC_INIT;
         good_ff <= '0;
         fmt_ff <= '0;
         crcerr_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         crc_ff <= crc_in;
         good_ff <= good_in;
         fmt_ff <= fmt_in;
         crcerr_ff <= crcerr_in;
         rv_ff <= rv_in;
      end
   end

   assign rsp.valid = rv_ff;
   assign rsp.frame_status = o_status_ff;
   assign rsp.message_type = o_type_ff;
   assign rsp.payload_length = o_plen_ff;
   assign rsp.data_byte = o_data_ff;
   assign rsp.data_present = o_present_ff;
   assign rsp.byte_position = o_pos_ff;
   assign rsp.last_of_run = o_last_ff;
   assign rsp.good_frames = good_ff;
   assign rsp.format_errors = fmt_ff;
   assign rsp.crc_errors = crcerr_ff;

endmodule

/* sim/tb_stuffed_frame_receiver_crc16.sv */
// testbench for stuffed_frame_receiver_crc16: directed table then random framed traffic
// depends on fsr_pkg, fsr_req_if and fsr_rsp_if from src; predicts each response locally
module tb_stuffed_frame_receiver_crc16;
   timeunit 1ns;
   timeprecision 1ps;

   import fsr_pkg::*;

   localparam int MAX_PAYLOAD = 64;
   localparam int STORE_BYTES = MAX_PAYLOAD + 5;
   localparam int LINGER_CYCLES = 16;
   localparam int DIRECTED_ROWS = 27;
   localparam int PHASES = 5;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  type_byte;
      logic [6:0]  plen;
      logic [7:0]  data;
      logic        present;
      logic [5:0]  pos;
      logic        last;
      logic [31:0] good;
      logic [31:0] fmt;
      logic [31:0] crcs;
   } frame_rsp_type;

   typedef enum logic [1:0] {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO, SRC_CRC_LO_BAD} byte_src_type;
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_STATUS} row_chk_type;

   typedef struct packed {
      byte_src_type src;
      logic [7:0]   value;
      row_chk_type  chk;
      logic [2:0]   status;
   } directed_row_type;

   typedef enum logic [2:0] {
      FR_GOOD, FR_MAX, FR_CRC_BAD, FR_MISMATCH, FR_BAD_LEN, FR_SHORT, FR_OVERFLOW
   } frame_kind_type;

   localparam directed_row_type DIRECTED[DIRECTED_ROWS] = '{
      // idle line noise
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'hFF, CHK_NONE, ST_OK},
      // empty frame
      '{SRC_LIT, 8'h7E, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7E, CHK_STATUS, ST_SHORT},
      // good frame, no payload
      '{SRC_LIT, 8'h7E, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h01, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'hFF, CHK_NONE, ST_OK},
      '{SRC_CRC_HI, 8'h00, CHK_NONE, ST_OK},
      '{SRC_CRC_LO, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7E, CHK_MODEL, ST_OK},
      // escaped flag and escaped escape land in the length field
      '{SRC_LIT, 8'h7E, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7D, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h5E, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7D, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h5D, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7E, CHK_STATUS, ST_BADLEN},
      // corrupted checksum
      '{SRC_LIT, 8'h7E, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h01, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h00, CHK_NONE, ST_OK},
      '{SRC_CRC_HI, 8'h00, CHK_NONE, ST_OK},
      '{SRC_CRC_LO_BAD, 8'h00, CHK_NONE, ST_OK},
      '{SRC_LIT, 8'h7E, CHK_STATUS, ST_CRC}
   };

   localparam int GAP_PCT[PHASES]   = '{0, 75, 0, 26, 26};
   localparam int STALL_PCT[PHASES] = '{0, 0, 75, 26, 26};
   localparam int PHASE_BYTES[PHASES] = '{1, 8, 8, 8, 8};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   fsr_req_if req_chan();
   fsr_rsp_if rsp_chan();

   stuffed_frame_receiver_crc16 u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // local copy of the receiver state
   logic [7:0]  cfg_flag, cfg_escape, cfg_mask;
   bit          rx_open, rx_escaped;
   int unsigned rx_fill;
   logic [7:0]  rx_buf [STORE_BYTES];
   logic [31:0] good_cnt, format_cnt, crc_cnt;

   frame_rsp_type line_results[$];
   frame_rsp_type awaited_results[$];
   frame_rsp_type want;
   int            gap_pct, stall_pct;
   int            line_bytes;
   int            mismatches;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] value);
      logic [15:0] c;
      c = crc ^ {value, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] stored_crc(int unsigned count);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int unsigned i = 0; i < count; i++) begin
         c = crc16_step(c, rx_buf[i]);
      end
      return c;
   endfunction

   function automatic frame_rsp_type make_rsp(logic [2:0] status, logic [7:0] type_byte,
                                              logic [6:0] plen, logic [7:0] data,
                                              logic present, logic [5:0] pos, logic last);
      frame_rsp_type r;
      r = '{status, type_byte, plen, data, present, pos, last, good_cnt, format_cnt, crc_cnt};
      return r;
   endfunction

   task automatic close_frame();
      int unsigned len, plen;
      len = {rx_buf[0], rx_buf[1]};
      plen = len - 1;
      if (rx_fill < 5) begin
         format_cnt++;
         line_results.push_back(make_rsp(ST_SHORT, 0, 0, 0, 0, 0, 1));
      end else if (len < 1 || len > MAX_PAYLOAD + 1) begin
         format_cnt++;
         line_results.push_back(make_rsp(ST_BADLEN, 0, 0, 0, 0, 0, 1));
      end else if (rx_fill != len + 4) begin
         format_cnt++;
         line_results.push_back(make_rsp(ST_MISMATCH, 0, 0, 0, 0, 0, 1));
      end else if ({rx_buf[rx_fill-2], rx_buf[rx_fill-1]} != stored_crc(rx_fill - 2)) begin
         crc_cnt++;
         line_results.push_back(make_rsp(ST_CRC, 0, 0, 0, 0, 0, 1));
      end else begin
         good_cnt++;
         if (plen == 0) begin
            line_results.push_back(make_rsp(ST_OK, rx_buf[2], 0, 0, 0, 0, 1));
         end else begin
            for (int unsigned i = 0; i < plen; i++) begin
               line_results.push_back(make_rsp(ST_OK, rx_buf[2], 7'(plen), rx_buf[3+i], 1,
                                               6'(i), (i + 1 == plen)));
            end
         end
      end
   endtask

   // unstuff one line byte and collect the responses it causes
   task automatic unstuff_byte(logic [7:0] raw);
      logic [7:0] b;
      b = raw;
      line_results.delete();
      if (!rx_open) begin
         if (b == cfg_flag) begin
            rx_open = 1;
            rx_fill = 0;
            rx_escaped = 0;
         end
         return;
      end
      if (rx_escaped) begin
         b = b ^ cfg_mask;
         rx_escaped = 0;
      end else if (b == cfg_escape) begin
         rx_escaped = 1;
         return;
      end else if (b == cfg_flag) begin
         rx_open = 0;
         close_frame();
         return;
      end
      if (rx_fill < STORE_BYTES) begin
         rx_buf[rx_fill] = b;
         rx_fill++;
      end else begin
         format_cnt++;
         rx_open = 0;
         rx_escaped = 0;
         line_results.push_back(make_rsp(ST_OVERFLOW, 0, 0, 0, 0, 0, 1));
      end
   endtask

   task automatic report_error(string msg);
      if (mismatches < 100) $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val) report_error($sformatf("%s got %0h expected %0h", name, got, exp_val));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
         if (awaited_results.size() == 0) begin
            report_error("response transaction with nothing pending");
         end else begin
            want = awaited_results.pop_front();
            check_field("frame_status", rsp_chan.frame_status, want.status);
            check_field("message_type", rsp_chan.message_type, want.type_byte);
            check_field("payload_length", rsp_chan.payload_length, want.plen);
            check_field("data_byte", rsp_chan.data_byte, want.data);
            check_field("data_present", rsp_chan.data_present, want.present);
            check_field("byte_position", rsp_chan.byte_position, want.pos);
            check_field("last_of_run", rsp_chan.last_of_run, want.last);
            check_field("good_frames", rsp_chan.good_frames, want.good);
            check_field("format_errors", rsp_chan.format_errors, want.fmt);
            check_field("crc_errors", rsp_chan.crc_errors, want.crcs);
         end
      end
   end

   task automatic send_line_byte(logic [7:0] value, row_chk_type chk = CHK_MODEL,
                                 logic [2:0] pin = ST_OK);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= value;
      do @(posedge clock); while (!req_chan.ready);
      if (rx_open || value == cfg_flag) line_bytes++;
      unstuff_byte(value);
      case (chk)
         CHK_MODEL: foreach (line_results[i]) awaited_results.push_back(line_results[i]);
         CHK_STATUS: awaited_results.push_back(make_rsp(pin, 0, 0, 0, 0, 0, 1));
         default: ;
      endcase
   endtask

   task automatic send_stuffed(logic [7:0] value, row_chk_type chk = CHK_MODEL,
                               logic [2:0] pin = ST_OK);
      if (value == cfg_flag || value == cfg_escape || $urandom_range(15) == 0) begin
         send_line_byte(cfg_escape);
         send_line_byte(value ^ cfg_mask, chk, pin);
      end else begin
         send_line_byte(value, chk, pin);
      end
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (awaited_results.size() != 0) @(negedge clock);
      repeat (LINGER_CYCLES) @(negedge clock);
   endtask

   task automatic close_open_frame();
      while (rx_open) send_line_byte(cfg_flag);
   endtask

   task automatic program_csrs(logic [7:0] flag, logic [7:0] escape, logic [7:0] mask);
      csr_write <= 1'b1;
      csr_index <= CSR_FLAG_BYTE;
      csr_data <= flag;
      @(negedge clock);
      csr_index <= CSR_ESCAPE_BYTE;
      csr_data <= escape;
      @(negedge clock);
      csr_index <= CSR_ESCAPE_MASK;
      csr_data <= mask;
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_flag = flag;
      cfg_escape = escape;
      cfg_mask = mask;
   endtask

   task automatic send_frame(frame_kind_type kind);
      logic [7:0]  body[$];
      logic [15:0] len, crc;
      logic [7:0]  b;
      int          plen, idx, keep;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom); while (b == cfg_flag);
            send_line_byte(b);
         end
      end
      plen = (kind == FR_MAX) ? MAX_PAYLOAD : $urandom_range(0, 5);
      len = 16'(plen + 1);
      if (kind == FR_BAD_LEN) begin
         len = $urandom_range(1) ? 16'd0 : 16'($urandom_range(MAX_PAYLOAD + 2, 65535));
      end
      if (kind == FR_OVERFLOW) begin
         repeat ($urandom_range(STORE_BYTES + 1, STORE_BYTES + 4)) body.push_back(8'($urandom));
      end else begin
         body.push_back(len[15:8]);
         body.push_back(len[7:0]);
         body.push_back(8'($urandom));
         repeat (plen) begin
            b = 8'($urandom);
            if ($urandom_range(3) == 0) b = $urandom_range(1) ? cfg_flag : cfg_escape;
            body.push_back(b);
         end
         crc = 16'hFFFF;
         foreach (body[i]) crc = crc16_step(crc, body[i]);
         body.push_back(crc[15:8]);
         body.push_back(crc[7:0]);
      end
      case (kind)
         FR_CRC_BAD: begin
            idx = $urandom_range(2, body.size() - 1);
            body[idx] = body[idx] ^ 8'(1 << $urandom_range(7));
         end
         FR_MISMATCH: begin
            if (plen > 0 && $urandom_range(1)) body.delete(3);
            else body.insert(3, 8'($urandom));
         end
         FR_SHORT: begin
            keep = $urandom_range(0, 4);
            while (body.size() > keep) void'(body.pop_back());
         end
         default: ;
      endcase
      send_line_byte(cfg_flag);
      foreach (body[i]) send_stuffed(body[i]);
      send_line_byte(cfg_flag);
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 55) return FR_GOOD;
      if (r < 65) return FR_CRC_BAD;
      if (r < 73) return FR_MISMATCH;
      if (r < 80) return FR_BAD_LEN;
      if (r < 87) return FR_SHORT;
      if (r < 92) return FR_OVERFLOW;
      if (r < 95) return FR_MAX;
      return FR_GOOD;
   endfunction

   initial begin
      #200000;
      $display("tb_stuffed_frame_receiver_crc16 NOT OK");
      $finish;
   end

   initial begin : stimulus
      directed_row_type row;
      logic [15:0]      crc;
      logic [7:0]       b, f, e;
      int               phase_start, frame_no;
      frame_kind_type   kind;

      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_FLAG_BYTE;
      csr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready = 1'b0;
      cfg_flag = 8'h7E;
      cfg_escape = 8'h7D;
      cfg_mask = 8'h20;
      rx_open = 0;
      rx_escaped = 0;
      rx_fill = 0;
      foreach (rx_buf[i]) rx_buf[i] = '0;
      good_cnt = '0;
      format_cnt = '0;
      crc_cnt = '0;
      line_bytes = 0;
      mismatches = 0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.src == SRC_LIT) begin
            send_line_byte(row.value, row.chk, row.status);
         end else begin
            crc = stored_crc(row.src == SRC_CRC_HI ? rx_fill : rx_fill - 1);
            case (row.src)
               SRC_CRC_HI: b = crc[15:8];
               SRC_CRC_LO: b = crc[7:0];
               default: b = ~crc[7:0];
            endcase
            send_stuffed(b, row.chk, row.status);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         gap_pct = GAP_PCT[p];
         stall_pct = STALL_PCT[p];
         if (p > 0) begin
            close_open_frame();
            hold_until_drained();
            case (p)
               1: program_csrs(8'h00, 8'hFF, 8'hFF);
               2: program_csrs(8'hFF, 8'h00, 8'h00);
               3: begin
                  f = 8'($urandom);
                  do e = 8'($urandom); while (e == f);
                  program_csrs(f, e, 8'($urandom));
               end
               default: begin
                  // flag and escape share a value, so frames only end by overflow
                  f = 8'($urandom);
                  program_csrs(f, f, 8'($urandom));
               end
            endcase
         end
         phase_start = line_bytes;
         frame_no = 0;
         while (line_bytes - phase_start < PHASE_BYTES[p]) begin
            kind = pick_kind();
            if (p == 0 && frame_no == 0) kind = FR_MAX;
            send_frame(kind);
            if ((p == 0 && frame_no == 0) || $urandom_range(11) == 0) hold_until_drained();
            frame_no++;
         end
      end

      hold_until_drained();
      if (mismatches == 0) begin
         $display("tb_stuffed_frame_receiver_crc16 OK");
      end else begin
         $display("tb_stuffed_frame_receiver_crc16 NOT OK");
      end
      $finish;
   end

endmodule
